>>> hdl/tspa_pkg.sv
// shared types and constants for the task slot and pid allocator
package tspa_pkg;

  localparam int TABLE_SLOTS_DEF = 64;

  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int USER_W    = 16;
  localparam int ID_W      = 15;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OCCUPY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TASKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREE  = 1'd1;

  localparam logic [CFG_W-1:0] MAX_TASKS_RST = 7'd32;
  localparam logic [CFG_W-1:0] MIN_FREE_RST  = 7'd4;

  localparam logic [ID_W-1:0] ID_MAX   = 15'h7fff;
  localparam logic [ID_W-1:0] ID_FIRST = 15'd1;

  typedef struct packed {
    logic              live;
    logic [USER_W-1:0] user;
    logic [ID_W-1:0]   pid;
    logic [ID_W-1:0]   grp;
    logic [ID_W-1:0]   ses;
  } entry_t;

  typedef struct packed {
    logic clear_en;
    logic take;
    logic advance;
    logic scan_en;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic collide;
    logic scan_done;
  } dp_sts_t;

endpackage

>>> hdl/tspa_dp.sv
// datapath: task table memory, id counter, scan pipeline, statistics and result registers
module tspa_dp #(
  parameter int TABLE_SLOTS = tspa_pkg::TABLE_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tspa_pkg::ctrl_cmd_t              cmd,
  output tspa_pkg::dp_sts_t                sts,
  input  logic [tspa_pkg::KIND_W-1:0]      in_kind,
  input  logic [tspa_pkg::SLOT_W-1:0]      in_slot,
  input  logic [tspa_pkg::USER_W-1:0]      in_user_id,
  input  logic [tspa_pkg::ID_W-1:0]        in_proc_id,
  input  logic [tspa_pkg::ID_W-1:0]        in_group_id,
  input  logic [tspa_pkg::ID_W-1:0]        in_session_id,
  input  logic                             cfg_we,
  input  logic [tspa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tspa_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_status,
  output logic [tspa_pkg::SLOT_W-1:0]      out_free_slot,
  output logic [tspa_pkg::ID_W-1:0]        out_new_pid
);

  localparam int AW   = $clog2(TABLE_SLOTS);
  localparam int SW   = tspa_pkg::SLOT_W;
  localparam int CMPW = (AW > tspa_pkg::CFG_W) ? AW : tspa_pkg::CFG_W;
  localparam int CHKW = (AW + 1 > SW) ? AW + 1 : SW;
  localparam logic [AW-1:0] LAST  = AW'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] FIRST = AW'(1);

  tspa_pkg::entry_t mem [TABLE_SLOTS];
  tspa_pkg::entry_t rd_data_r;
  tspa_pkg::entry_t wr_data;

  logic [AW-1:0]                   rd_addr_r;
  logic                            iss_busy_r;
  logic                            pv_r;
  logic [AW-1:0]                   pidx_r;
  logic [tspa_pkg::ID_W-1:0]       id_ctr_r;
  logic [tspa_pkg::ID_W-1:0]       id_nxt;
  logic [AW-1:0]                   free_cnt_r;
  logic [AW-1:0]                   user_cnt_r;
  logic [AW-1:0]                   lowest_r;
  logic                            have_free_r;
  logic [tspa_pkg::CFG_W-1:0]      max_tasks_r;
  logic [tspa_pkg::CFG_W-1:0]      min_free_r;
  logic [tspa_pkg::KIND_W-1:0]     req_kind_r;
  logic [tspa_pkg::USER_W-1:0]     req_user_r;
  logic                            slot_ok_r;

  logic          slot_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          hit;
  logic          alloc_fail;

  assign slot_ok = CHKW'(in_slot) < CHKW'(TABLE_SLOTS);
  assign id_nxt  = (id_ctr_r == tspa_pkg::ID_MAX) ? tspa_pkg::ID_FIRST : id_ctr_r + 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = '0;
    if (cmd.clear_en) begin
      wr_en = 1'b1;
    end else if (cmd.take && slot_ok &&
                 (in_kind == tspa_pkg::KIND_OCCUPY || in_kind == tspa_pkg::KIND_FREE)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(in_slot);
      if (in_kind == tspa_pkg::KIND_OCCUPY) begin
        wr_data.live = 1'b1;
        wr_data.user = in_user_id;
        wr_data.pid  = in_proc_id;
        wr_data.grp  = in_group_id;
        wr_data.ses  = in_session_id;
      end
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  assign hit = rd_data_r.live &&
               (rd_data_r.pid == id_ctr_r || rd_data_r.grp == id_ctr_r ||
                rd_data_r.ses == id_ctr_r);

  assign sts.collide    = pv_r && hit;
  assign sts.scan_done  = pv_r && !hit && (pidx_r == LAST);
  assign sts.clear_done = (rd_addr_r == LAST);

  // read address, issue and evaluate stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r  <= '0;
      iss_busy_r <= 1'b0;
      pv_r       <= 1'b0;
      id_ctr_r   <= '0;
    end else if (cmd.clear_en) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end else if (cmd.advance) begin
      id_ctr_r   <= id_nxt;
      rd_addr_r  <= FIRST;
      iss_busy_r <= 1'b1;
      pv_r       <= 1'b0;
    end else if (cmd.scan_en && iss_busy_r) begin
      pv_r <= 1'b1;
      if (rd_addr_r == LAST) begin
        iss_busy_r <= 1'b0;
      end else begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
    end else begin
      pv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= rd_addr_r;
  end

  // free and per-user counts, lowest free slot
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      free_cnt_r  <= '0;
      user_cnt_r  <= '0;
      have_free_r <= 1'b0;
      lowest_r    <= '0;
    end else if (pv_r && !hit) begin
      if (!rd_data_r.live) begin
        free_cnt_r <= free_cnt_r + 1'b1;
        if (!have_free_r) begin
          have_free_r <= 1'b1;
          lowest_r    <= pidx_r;
        end
      end else if (rd_data_r.user == req_user_r) begin
        user_cnt_r <= user_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_kind_r <= in_kind;
      req_user_r <= in_user_id;
      slot_ok_r  <= slot_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tasks_r <= tspa_pkg::MAX_TASKS_RST;
      min_free_r  <= tspa_pkg::MIN_FREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tspa_pkg::CFG_MAX_TASKS: max_tasks_r <= cfg_data;
        tspa_pkg::CFG_MIN_FREE:  min_free_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign alloc_fail = !have_free_r ||
                      (req_user_r != '0 &&
                       (CMPW'(free_cnt_r) <= CMPW'(min_free_r) ||
                        CMPW'(user_cnt_r) > CMPW'(max_tasks_r)));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (req_kind_r)
        tspa_pkg::KIND_ALLOC: begin
          out_status    <= alloc_fail;
          out_free_slot <= alloc_fail ? '0 : SW'(lowest_r);
          out_new_pid   <= id_ctr_r;
        end
        tspa_pkg::KIND_OCCUPY, tspa_pkg::KIND_FREE: begin
          out_status    <= !slot_ok_r;
          out_free_slot <= '0;
          out_new_pid   <= '0;
        end
        default: begin
          out_status    <= 1'b1;
          out_free_slot <= '0;
          out_new_pid   <= '0;
        end
      endcase
    end
  end

endmodule

>>> hdl/tspa_ctrl.sv
// controller: clearing pass, item sequencing and result handshake
module tspa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tspa_pkg::KIND_W-1:0]  in_kind,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tspa_pkg::ctrl_cmd_t          cmd,
  input  tspa_pkg::dp_sts_t            sts
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   take;
  logic   load;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign load      = (state_r == ST_RESP) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  assign cmd.clear_en = (state_r == ST_CLEAR);
  assign cmd.take     = take;
  assign cmd.advance  = (take && in_kind == tspa_pkg::KIND_ALLOC) ||
                        ((state_r == ST_SCAN) && sts.collide);
  assign cmd.scan_en  = (state_r == ST_SCAN);
  assign cmd.load_out = load;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          state_nxt = (in_kind == tspa_pkg::KIND_ALLOC) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: if (sts.scan_done) state_nxt = ST_RESP;
      ST_RESP: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/task_slot_and_pid_allocator_top.sv
// top level of the task slot and pid allocator
//
// items arrive on the in_ channel (valid/stall) and each gives exactly one result transfer
// on the out_ channel. kind allocate advances the 15-bit id counter until the id clashes with
// no live process, group or session id, then reports the lowest free slot above 0 and the new
// id, or status 1 when no slot is free or a non-root user is over its limits. kind occupy
// writes a slot, kind free clears it. an allocate walks the table through its single read
// port, one slot a cycle, and walks it again from slot 1 for every id clash.
// one item is in work at a time; the next is taken once the result sits in the output
// register, so a stalled receiver holds at most one result and one item in work.
// the cfg_ port (valid/ready) writes the per-user slot limit (index 0) and min_free_for_root
// (index 1); it is ready whenever reset is released.
// after reset a clearing pass marks every slot free, with in_stall high throughout.
// reset is synchronous, active low; the id counter restarts from zero.
module task_slot_and_pid_allocator_top #(
  parameter int TABLE_SLOTS = tspa_pkg::TABLE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tspa_pkg::KIND_W-1:0]     in_kind,
  input  logic [tspa_pkg::SLOT_W-1:0]     in_slot,
  input  logic [tspa_pkg::USER_W-1:0]     in_user_id,
  input  logic [tspa_pkg::ID_W-1:0]       in_proc_id,
  input  logic [tspa_pkg::ID_W-1:0]       in_group_id,
  input  logic [tspa_pkg::ID_W-1:0]       in_session_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [tspa_pkg::SLOT_W-1:0]     out_free_slot,
  output logic [tspa_pkg::ID_W-1:0]       out_new_pid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tspa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tspa_pkg::CFG_W-1:0]      cfg_data
);

  tspa_pkg::ctrl_cmd_t cmd;
  tspa_pkg::dp_sts_t   sts;

  assign cfg_ready = rst_n;

  tspa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tspa_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_slot       (in_slot),
    .in_user_id    (in_user_id),
    .in_proc_id    (in_proc_id),
    .in_group_id   (in_group_id),
    .in_session_id (in_session_id),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_status    (out_status),
    .out_free_slot (out_free_slot),
    .out_new_pid   (out_new_pid)
  );

endmodule

>>> hdl/tspa_chk.sv
// port-level checker for the task slot and pid allocator, with its bind
module tspa_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_status,
  input logic [tspa_pkg::SLOT_W-1:0]  out_free_slot,
  input logic [tspa_pkg::ID_W-1:0]    out_new_pid
);

  // clearing pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in work");

  // a failed result never names a slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_free_slot == '0))
    else $error("failure result carries a slot");

  // a granted slot always comes with a non-zero id
  a_slot_has_pid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_free_slot != '0) |-> (out_new_pid != '0))
    else $error("slot granted with zero id");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind task_slot_and_pid_allocator_top tspa_chk u_tspa_chk (.*);

>>> verif/task_slot_and_pid_allocator_top_test.sv
// testbench for the task slot and pid allocator: table and id predictor with scoreboard
module task_slot_and_pid_allocator_top_test;
  import tspa_pkg::*;

  localparam int NSLOTS = TABLE_SLOTS_DEF;
  localparam int PID_TRIES = 32768;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_PRINTED = 100;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [USER_W-1:0] user;
    logic [ID_W-1:0]   pid;
    logic [ID_W-1:0]   grp;
    logic [ID_W-1:0]   ses;
  } item_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] free_slot;
    logic [ID_W-1:0]   new_pid;
  } reply_t;

  class alloc_scoreboard;
    bit                slot_busy[NSLOTS];
    logic [USER_W-1:0] slot_owner[NSLOTS];
    logic [ID_W-1:0]   slot_pid[NSLOTS];
    logic [ID_W-1:0]   slot_grp[NSLOTS];
    logic [ID_W-1:0]   slot_ses[NSLOTS];
    logic [ID_W-1:0]   pid_ctr;
    logic [CFG_W-1:0]  max_tasks;
    logic [CFG_W-1:0]  min_free;
    reply_t            awaited_replies[$];
    int                errors;

    function new();
      pid_ctr = '0;
      max_tasks = MAX_TASKS_RST;
      min_free = MIN_FREE_RST;
      errors = 0;
      foreach (slot_busy[i]) begin
        slot_busy[i] = 1'b0;
        slot_owner[i] = '0;
        slot_pid[i] = '0;
        slot_grp[i] = '0;
        slot_ses[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MAX_TASKS) max_tasks = val;
      else if (idx == CFG_MIN_FREE) min_free = val;
    endfunction

    function bit id_taken(logic [ID_W-1:0] id);
      for (int i = 1; i < NSLOTS; i++) begin
        if (slot_busy[i] && (slot_pid[i] == id || slot_grp[i] == id || slot_ses[i] == id))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void step_pid();
      if (pid_ctr == ID_MAX) pid_ctr = ID_FIRST;
      else pid_ctr = pid_ctr + 1'b1;
    endfunction

    function reply_t compute_reply(item_t it);
      reply_t r;
      int free_cnt;
      int own_cnt;
      int tries;
      r = '0;
      free_cnt = 0;
      own_cnt = 0;
      case (it.kind)
        KIND_ALLOC: begin
          step_pid();
          tries = 1;
          while (tries < PID_TRIES && id_taken(pid_ctr)) begin
            step_pid();
            tries++;
          end
          // downward walk leaves the lowest free slot
          for (int i = NSLOTS - 1; i > 0; i--) begin
            if (!slot_busy[i]) begin
              r.free_slot = SLOT_W'(i);
              free_cnt++;
            end else if (slot_owner[i] == it.user) begin
              own_cnt++;
            end
          end
          r.new_pid = pid_ctr;
          if (free_cnt == 0) begin
            r.status = 1'b1;
          end else if (it.user != 0 && (free_cnt <= min_free || own_cnt > max_tasks)) begin
            r.status = 1'b1;
            r.free_slot = '0;
          end
        end
        KIND_OCCUPY: begin
          slot_busy[it.slot] = 1'b1;
          slot_owner[it.slot] = it.user;
          slot_pid[it.slot] = it.pid;
          slot_grp[it.slot] = it.grp;
          slot_ses[it.slot] = it.ses;
        end
        KIND_FREE: slot_busy[it.slot] = 1'b0;
        default: r.status = 1'b1;
      endcase
      return r;
    endfunction

    function reply_t note_item(item_t it);
      reply_t r;
      r = compute_reply(it);
      awaited_replies.push_back(r);
      return r;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task check_reply(reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        report($sformatf("unexpected result transfer %0d/%0d/%0d",
                         got.status, got.free_slot, got.new_pid));
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.free_slot !== want.free_slot)
        report($sformatf("free_slot %0d, expected %0d", got.free_slot, want.free_slot));
      if (got.new_pid !== want.new_pid)
        report($sformatf("new_pid %0d, expected %0d", got.new_pid, want.new_pid));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [SLOT_W-1:0]    in_slot = '0;
  logic [USER_W-1:0]    in_user_id = '0;
  logic [ID_W-1:0]      in_proc_id = '0;
  logic [ID_W-1:0]      in_group_id = '0;
  logic [ID_W-1:0]      in_session_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_status;
  logic [SLOT_W-1:0]    out_free_slot;
  logic [ID_W-1:0]      out_new_pid;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  alloc_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  task_slot_and_pid_allocator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_slot(in_slot),
    .in_user_id(in_user_id),
    .in_proc_id(in_proc_id),
    .in_group_id(in_group_id),
    .in_session_id(in_session_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_free_slot(out_free_slot),
    .out_new_pid(out_new_pid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_reply(reply_t'{out_status, out_free_slot, out_new_pid});
  end

  function automatic item_t mk(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                               logic [USER_W-1:0] u, logic [ID_W-1:0] p,
                               logic [ID_W-1:0] g, logic [ID_W-1:0] e);
    return '{k, s, u, p, g, e};
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom_range(ID_MAX));
  endfunction

  // ids just ahead of the counter force retries
  function automatic logic [ID_W-1:0] near_id();
    return sb.pid_ctr + ID_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [USER_W-1:0] pick_user();
    int r;
    r = $urandom_range(99);
    if (r < 35) return '0;
    if (r < 80) return USER_W'($urandom_range(1, 3));
    return USER_W'($urandom_range(16'hffff));
  endfunction

  task automatic send_item(input item_t it, output reply_t rep);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_slot <= it.slot;
    in_user_id <= it.user;
    in_proc_id <= it.pid;
    in_group_id <= it.grp;
    in_session_id <= it.ses;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (in_stall === 1'b0) taken = 1'b1;
      else @(negedge clk);
    end
    rep = sb.note_item(it);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, CFG_W'(val));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    reply_t rep;
    send_item(mk(KIND_ALLOC, 0, 0, 0, 0, 0), rep);
    send_item(mk(KIND_OCCUPY, 0, 0, 2, 3, 4), rep);
    send_item(mk(KIND_ALLOC, 6'd63, 16'hffff, ID_MAX, ID_MAX, ID_MAX), rep);
    send_item(mk(KIND_OCCUPY, 1, 16'hffff, 3, 4, 5), rep);
    send_item(mk(KIND_ALLOC, 0, 1, 0, 0, 0), rep);
    send_item(mk(KIND_OCCUPY, 6'd63, 16'hffff, ID_MAX, ID_MAX, 0), rep);
    send_item(mk(KIND_OCCUPY, 1, 0, 7, 8, ID_MAX), rep);
    send_item(mk(KIND_ALLOC, 0, 16'hffff, 0, 0, 0), rep);
    send_item(mk(KIND_FREE, 5, 0, 0, 0, 0), rep);
    send_item(mk(KIND_FREE, 0, 0, 0, 0, 0), rep);
    send_item(mk(KIND_UNUSED, 6'd63, 16'hffff, ID_MAX, ID_MAX, ID_MAX), rep);
    send_item(mk(KIND_UNUSED, 0, 0, 0, 0, 0), rep);
    send_item(mk(KIND_OCCUPY, 2, 0, 0, 0, 0), rep);
    send_item(mk(KIND_ALLOC, 0, 0, 0, 0, 0), rep);
    send_item(mk(KIND_ALLOC, 0, 2, 0, 0, 0), rep);
    send_item(mk(KIND_FREE, 6'd63, 0, 0, 0, 0), rep);
    send_item(mk(KIND_FREE, 1, 0, 0, 0, 0), rep);
    send_item(mk(KIND_FREE, 2, 0, 0, 0, 0), rep);
    send_item(mk(KIND_ALLOC, 0, 0, 0, 0, 0), rep);
  endtask

  // forks (allocate then occupy the slot it found), exits, planted clashes and noise
  task automatic run_phase(input int n_items, input int fork_pct, input int exit_pct);
    int sent;
    int r;
    item_t it;
    reply_t rep;
    int live_q[$];
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < fork_pct) begin
        it = mk(KIND_ALLOC, SLOT_W'($urandom_range(63)), pick_user(), rand_id(), rand_id(),
                rand_id());
        send_item(it, rep);
        sent++;
        if (rep.status == 1'b0) begin
          it = mk(KIND_OCCUPY, rep.free_slot, it.user, rep.new_pid,
                  $urandom_range(1) ? rep.new_pid : near_id(),
                  $urandom_range(1) ? rep.new_pid : near_id());
          send_item(it, rep);
          sent++;
        end
      end else if (r < fork_pct + exit_pct) begin
        live_q.delete();
        for (int k = 0; k < NSLOTS; k++) if (sb.slot_busy[k]) live_q.push_back(k);
        it = mk(KIND_FREE, SLOT_W'($urandom_range(63)), pick_user(), rand_id(), rand_id(),
                rand_id());
        if (live_q.size() != 0) it.slot = SLOT_W'(live_q[$urandom_range(live_q.size() - 1)]);
        send_item(it, rep);
        sent++;
      end else if (r < fork_pct + exit_pct + 8) begin
        send_item(mk(KIND_OCCUPY, SLOT_W'($urandom_range(1, 63)), pick_user(), near_id(),
                     near_id(), near_id()), rep);
        sent++;
      end else begin
        send_item(mk(KIND_W'($urandom_range(3)), SLOT_W'($urandom_range(63)),
                     USER_W'($urandom_range(16'hffff)), rand_id(), rand_id(), rand_id()), rep);
        sent++;
      end
    end
  endtask

  initial begin
    int max_val;
    int min_val;
    int fork_pct;
    int exit_pct;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    end_burst();
    wait_drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 68; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 68; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      case (ph)
        0: begin max_val = 32; min_val = 4; fork_pct = 45; exit_pct = 25; end
        1: begin max_val = 0; min_val = 0; fork_pct = 40; exit_pct = 30; end
        2: begin max_val = 64; min_val = 64; fork_pct = 45; exit_pct = 25; end
        3: begin
          max_val = $urandom_range(1, 10);
          min_val = $urandom_range(2, 8);
          fork_pct = 70;
          exit_pct = 8;
        end
        4: begin max_val = 3; min_val = 10; fork_pct = 70; exit_pct = 8; end
        default: begin max_val = 32; min_val = 4; fork_pct = 20; exit_pct = 60; end
      endcase
      if (ph != 0) begin
        write_reg(CFG_MAX_TASKS, max_val);
        write_reg(CFG_MIN_FREE, min_val);
      end
      run_phase(142, fork_pct, exit_pct);
      end_burst();
      wait_drain();
    end

    repeat (2 * NSLOTS + 16) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
